### rtl/latin_homoglyph_to_cyrillic_fixer_assert.svh
// Assertion macros for the homoglyph fixer back end.
`ifndef LATIN_HOMOGLYPH_TO_CYRILLIC_FIXER_ASSERT_SVH
`define LATIN_HOMOGLYPH_TO_CYRILLIC_FIXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HGFIX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hgfix: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HGFIX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hgfix: next-cycle check failed");

`endif

### rtl/hgfix_pkg.sv
// Shared types, constants and character classification for the homoglyph fixer.
`default_nettype none

package hgfix_pkg;

  localparam int CP_W         = 21;
  localparam int LEN_W        = 6;
  localparam int TDATA_W      = 24;
  localparam int MAX_WORD_DEF = 32;

  localparam logic [CP_W-1:0] CP_SPACE     = 21'd32;
  localparam logic [CP_W-1:0] CP_QMARK     = 21'd63;
  localparam logic [CP_W-1:0] CP_ASCII_MAX = 21'd127;
  localparam logic [CP_W-1:0] CP_CYR_FIRST = 21'd1040;
  localparam logic [CP_W-1:0] CP_CYR_LAST  = 21'd1103;

  // One finished word as handed from the front to the back.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] latin;
    logic [LEN_W-1:0] cyr;
    logic [LEN_W-1:0] look;
    logic [LEN_W-1:0] unk;
    logic             space;
    logic             last;
  } job_t;

  // Word buffer write from the front.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [CP_W-1:0]  data;
  } wr_t;

  // Bank release from the back once a word has been replayed.
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  // Cyrillic code point for a Latin look-alike, zero when there is none.
  function automatic logic [CP_W-1:0] lookalike_of(logic [CP_W-1:0] c);
    logic [CP_W-1:0] r;
    case (c)
      21'd65:  r = 21'h000410; // A
      21'd67:  r = 21'h000421; // C
      21'd69:  r = 21'h000415; // E
      21'd72:  r = 21'h00041D; // H
      21'd73:  r = 21'h000406; // I
      21'd75:  r = 21'h00041A; // K
      21'd77:  r = 21'h00041C; // M
      21'd79:  r = 21'h00041E; // O
      21'd80:  r = 21'h000420; // P
      21'd84:  r = 21'h000422; // T
      21'd97:  r = 21'h000430; // a
      21'd99:  r = 21'h000441; // c
      21'd101: r = 21'h000435; // e
      21'd105: r = 21'h000456; // i
      21'd111: r = 21'h00043E; // o
      21'd112: r = 21'h000440; // p
      21'd121: r = 21'h000443; // y
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_latin(logic [CP_W-1:0] c);
    return (c >= 21'd97 && c <= 21'd122) || (c >= 21'd65 && c <= 21'd90);
  endfunction

  function automatic logic is_cyrillic(logic [CP_W-1:0] c);
    return c >= CP_CYR_FIRST && c <= CP_CYR_LAST;
  endfunction

endpackage

`default_nettype wire

### rtl/latin_homoglyph_to_cyrillic_fixer.sv
// Top level of the Latin homoglyph to Cyrillic word fixer.
// The front takes one code point per cycle while a free word bank and a queue slot exist.
// After its ending code point, a word passes through the queue and the read state before it is offered.
// Replay steps through the read state, then the output state, for each buffered code point,
// through the space state for each space, and through the idle state to take each descriptor.
// Reset clears all control state at once; the word memory needs no clearing pass.
`default_nettype none

module latin_homoglyph_to_cyrillic_fixer #(
  parameter int MAX_WORD = hgfix_pkg::MAX_WORD_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire [hgfix_pkg::TDATA_W-1:0]  s_axis_tdata,  // [20:0] code_point, rest zero
  input  wire                           s_axis_tlast,  // last
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [hgfix_pkg::TDATA_W-1:0] m_axis_tdata,  // [20:0] code_point_res, rest zero
  output logic                          m_axis_tlast   // last_res
);
  import hgfix_pkg::*;

  logic push, pop, q_full, q_empty;
  job_t job_in, job_out;
  wr_t  wr;
  rel_t rel;

  hgfix_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (job_in),
    .wr_o          (wr),
    .rel_i         (rel)
  );

  hgfix_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  hgfix_back #(.MAX_WORD(MAX_WORD)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .job_i         (job_out),
    .pop_o         (pop),
    .wr_i          (wr),
    .rel_o         (rel),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### rtl/hgfix_front.sv
// Front end: accepts code points, classifies them and fills the word banks.
`default_nettype none

module hgfix_front #(
  parameter int MAX_WORD = hgfix_pkg::MAX_WORD_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [hgfix_pkg::TDATA_W-1:0] s_axis_tdata,  // [20:0] code_point, rest zero
  input  wire                          s_axis_tlast,  // last
  input  wire                          q_full_i,
  output logic                         push_o,
  output hgfix_pkg::job_t              job_o,
  output hgfix_pkg::wr_t               wr_o,
  input  wire hgfix_pkg::rel_t         rel_i
);
  import hgfix_pkg::*;

  logic             wr_bank_q, wr_bank_d;
  logic [1:0]       busy_q, busy_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] latin_q, latin_d, cyr_q, cyr_d, look_q, look_d, unk_q, unk_d;

  logic [CP_W-1:0]  cp;
  logic             accept, is_space, c_latin, c_look, c_cyr, c_unk;
  logic [LEN_W-1:0] len_inc, latin_n, cyr_n, look_n, unk_n, word_len;
  logic             end_word;

  // Classify the incoming code point.
  assign cp       = s_axis_tdata[CP_W-1:0];
  assign is_space = (cp == CP_SPACE);
  assign c_latin  = is_latin(cp);
  assign c_look   = c_latin && (lookalike_of(cp) != '0);
  assign c_cyr    = !c_latin && is_cyrillic(cp);
  assign c_unk    = !c_latin && !c_cyr && ((cp > CP_ASCII_MAX) || (cp == CP_QMARK));

  assign s_axis_tready = !q_full_i && !busy_q[wr_bank_q];
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Counts including the current code point.
  assign len_inc  = len_q + 1'b1;
  assign latin_n  = latin_q + LEN_W'(c_latin);
  assign cyr_n    = cyr_q + LEN_W'(c_look || c_cyr);
  assign look_n   = look_q + LEN_W'(c_look);
  assign unk_n    = unk_q + LEN_W'(c_unk);
  assign word_len = is_space ? len_q : len_inc;
  assign end_word = is_space || s_axis_tlast || (len_inc == LEN_W'(MAX_WORD));

  // Word descriptor for the back end.
  always_comb begin
    push_o      = accept && end_word;
    job_o.bank  = wr_bank_q;
    job_o.len   = word_len;
    job_o.latin = is_space ? latin_q : latin_n;
    job_o.cyr   = is_space ? cyr_q : cyr_n;
    job_o.look  = is_space ? look_q : look_n;
    job_o.unk   = is_space ? unk_q : unk_n;
    job_o.space = is_space;
    job_o.last  = s_axis_tlast;
  end

  // Buffer write of every non-space code point.
  always_comb begin
    wr_o.en   = accept && !is_space;
    wr_o.bank = wr_bank_q;
    wr_o.idx  = len_q;
    wr_o.data = cp;
  end

  // Word counters and bank ownership.
  always_comb begin
    len_d     = len_q;
    latin_d   = latin_q;
    cyr_d     = cyr_q;
    look_d    = look_q;
    unk_d     = unk_q;
    wr_bank_d = wr_bank_q;
    busy_d    = busy_q;
    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (end_word) begin
        len_d   = '0;
        latin_d = '0;
        cyr_d   = '0;
        look_d  = '0;
        unk_d   = '0;
        if (word_len != '0) begin
          busy_d[wr_bank_q] = 1'b1;
          wr_bank_d         = !wr_bank_q;
        end
      end else begin
        len_d   = len_inc;
        latin_d = latin_n;
        cyr_d   = cyr_n;
        look_d  = look_n;
        unk_d   = unk_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      latin_q   <= '0;
      cyr_q     <= '0;
      look_q    <= '0;
      unk_q     <= '0;
      wr_bank_q <= 1'b0;
      busy_q    <= '0;
    end else begin
      len_q     <= len_d;
      latin_q   <= latin_d;
      cyr_q     <= cyr_d;
      look_q    <= look_d;
      unk_q     <= unk_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
    end
  end

endmodule

`default_nettype wire

### rtl/hgfix_queue.sv
// Two-entry queue of word descriptors between the front and the back.
`default_nettype none

module hgfix_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire hgfix_pkg::job_t job_i,
  input  wire                  pop_i,
  output hgfix_pkg::job_t      job_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import hgfix_pkg::*;

  localparam int Depth = 2;

  job_t       entry_q [Depth];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = entry_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

### rtl/hgfix_back.sv
// Back end: judges each word and replays it from the banked word memory.
`default_nettype none
`include "latin_homoglyph_to_cyrillic_fixer_assert.svh"

module hgfix_back #(
  parameter int MAX_WORD = hgfix_pkg::MAX_WORD_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           q_empty_i,
  input  wire hgfix_pkg::job_t          job_i,
  output logic                          pop_o,
  input  wire hgfix_pkg::wr_t           wr_i,
  output hgfix_pkg::rel_t               rel_o,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [hgfix_pkg::TDATA_W-1:0] m_axis_tdata,  // [20:0] code_point_res, rest zero
  output logic                          m_axis_tlast   // last_res
);
  import hgfix_pkg::*;

  localparam int IdxW     = $clog2(MAX_WORD);
  localparam int MemDepth = 2 * (2 ** IdxW);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_OUT   = 4'b0100,
    ST_SPACE = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d, idx_q, idx_d;
  logic             bank_q, bank_d, cyr_q, cyr_d, space_q, space_d, last_q, last_d;
  logic [CP_W-1:0]  word_mem [MemDepth];
  logic [CP_W-1:0]  rd_q;

  logic [LEN_W:0]   mix_sum;
  logic             job_cyr, out_hs, last_char;
  logic [CP_W-1:0]  repl, out_cp;

  // Word test: few unknowns, and Cyrillic clearly outnumbers Latin.
  assign mix_sum = {1'b0, job_i.latin} + {1'b0, job_i.cyr} - {job_i.look, 1'b0};
  assign job_cyr = (job_i.unk < mix_sum[LEN_W:1]) && ((job_i.cyr >> 1) >= job_i.latin);

  assign out_hs    = m_axis_tvalid && m_axis_tready;
  assign last_char = (LEN_W'(idx_q + 1'b1) == len_q);
  assign repl      = cyr_q ? lookalike_of(rd_q) : '0;
  assign out_cp    = (state_q == ST_SPACE) ? CP_SPACE : ((repl != '0) ? repl : rd_q);

  // Output word.
  always_comb begin
    m_axis_tvalid = (state_q == ST_OUT) || (state_q == ST_SPACE);
    m_axis_tdata  = TDATA_W'(out_cp);
    m_axis_tlast  = ((state_q == ST_OUT) && last_q && !space_q && last_char) ||
                    ((state_q == ST_SPACE) && last_q);
  end

  // Replay sequencer.
  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    idx_d    = idx_q;
    bank_d   = bank_q;
    cyr_d    = cyr_q;
    space_d  = space_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    rel_o.en   = 1'b0;
    rel_o.bank = bank_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          len_d   = job_i.len;
          idx_d   = '0;
          bank_d  = job_i.bank;
          cyr_d   = job_cyr;
          space_d = job_i.space;
          last_d  = job_i.last;
          state_d = (job_i.len != '0) ? ST_READ : ST_SPACE;
        end
      end
      ST_READ: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_hs) begin
          idx_d = LEN_W'(idx_q + 1'b1);
          if (last_char) begin
            rel_o.en = 1'b1;
            state_d  = space_q ? ST_SPACE : ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_SPACE: begin
        if (out_hs) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      idx_q   <= '0;
      bank_q  <= 1'b0;
      cyr_q   <= 1'b0;
      space_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      bank_q  <= bank_d;
      cyr_q   <= cyr_d;
      space_q <= space_d;
      last_q  <= last_d;
    end
  end

  // Banked word memory: one write port from the front, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      word_mem[{wr_i.bank, wr_i.idx[IdxW-1:0]}] <= wr_i.data;
    end
    if (state_q == ST_READ) begin
      rd_q <= word_mem[{bank_q, idx_q[IdxW-1:0]}];
    end
  end

  `HGFIX_ASSERT_IMPL(a_idx_in_word, clk_i, rst_ni, state_q == ST_OUT, idx_q < len_q)
  `HGFIX_ASSERT_IMPL(a_job_len, clk_i, rst_ni, pop_o, job_i.len <= LEN_W'(MAX_WORD))
  `HGFIX_ASSERT_IMPL(a_release_on_hs, clk_i, rst_ni, rel_o.en, out_hs && state_q == ST_OUT)
  `HGFIX_ASSERT_NEXT(a_last_ends_job, clk_i, rst_ni, out_hs && m_axis_tlast, state_q == ST_IDLE)

endmodule

`default_nettype wire
